// File: src/wabs_pkg.sv
`default_nettype none

package wabs_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_STOP    = 2'd1;
  localparam logic [1:0] OP_RECHECK = 2'd2;
  localparam logic [1:0] OP_WRITE   = 2'd3;

  // phase codes
  localparam logic [1:0] PH_FIND = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_RUN     = 2'd1;
  localparam logic [1:0] CFG_SHORT   = 2'd2;
  localparam logic [1:0] CFG_LONG    = 2'd3;

  // configuration reset values
  localparam logic [4:0]  ENTRIES_RST = 5'd0;
  localparam logic [15:0] RUN_MS_RST  = 16'd20000;
  localparam logic [11:0] SHORT_MS_RST = 12'd100;
  localparam logic [11:0] LONG_MS_RST = 12'd500;

  typedef struct packed {
    logic       on;
    logic [6:0] days;
    logic [5:0] minute;
    logic [4:0] hour;
  } alarm_t;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [2:0] now_weekday;
    logic [3:0] entry_index;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [6:0] entry_days;
    logic       entry_on;
  } item_t;

  typedef struct packed {
    logic [4:0]  entries_in_use;
    logic [15:0] run_ms;
    logic [11:0] short_ms;
    logic [11:0] long_ms;
  } cfg_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [1:0] phase;
    logic [3:0] pending_index;
    logic       alarm_active;
  } res_t;

  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    alarm_t wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

// File: src/wabs_ram.sv
`default_nettype none

module wabs_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/wabs_table.sv
`default_nettype none

module wabs_table import wabs_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tbl_req_t      tbl_req,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] wr_addr,
  output alarm_t             rd_entry
);

  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   rd_valid_r;
  logic [$bits(alarm_t)-1:0] ram_q;

  wabs_ram #(
    .WIDTH ($bits(alarm_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (tbl_req.wr_en),
    .waddr (wr_addr),
    .wdata (tbl_req.wr_data),
    .re    (tbl_req.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // entries never written since reset read as a disabled all-zero alarm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (tbl_req.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (tbl_req.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_valid_r ? alarm_t'(ram_q) : '0;

endmodule

`default_nettype wire

// File: src/wabs_ctrl.sv
`default_nettype none

module wabs_ctrl import wabs_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_accept,
  input  wire item_t    item,
  input  wire cfg_t     cfg,
  output logic          idle,
  output logic          res_valid,
  input  wire logic     res_ready,
  output res_t          res,
  output tbl_req_t      tbl_req,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr,
  input  wire alarm_t   rd_entry
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_WCHK = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  item_t       item_r, item_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [15:0] run_r, run_nxt;
  logic [11:0] cyc_r, cyc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        buzz_r, buzz_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [6:0]  rd_idx_r, rd_idx_nxt;

  logic [10:0] now_mod;
  logic [10:0] ent_mod;
  logic [6:0]  day_bit;
  logic        hit;
  logic [6:0]  scan_n;
  logic [6:0]  idx_ext;
  logic [6:0]  pend_ext;
  logic [15:0] run_inc;
  logic [11:0] cyc_inc;
  logic [1:0]  ps;
  logic [11:0] cc;
  logic        bz;

  // hour*60 + minute as (h << 6) - (h << 2) + m
  function automatic logic [10:0] min_of_day(input logic [4:0] h, input logic [5:0] m);
    min_of_day = {h, 6'b0} - 11'({h, 2'b0}) + 11'(m);
  endfunction

  assign now_mod = min_of_day(item_r.now_hour, item_r.now_minute);
  assign ent_mod = min_of_day(rd_entry.hour, rd_entry.minute);
  assign day_bit = (item_r.now_weekday != 3'd0) ? (7'b1 << (item_r.now_weekday - 3'd1)) : '0;
  assign hit = rd_pend_r && rd_entry.on && (now_mod < ent_mod) && ((day_bit & rd_entry.days) != '0);

  assign scan_n = ({2'b0, cfg.entries_in_use} > 7'(TABLE_DEPTH)) ?
                  7'(TABLE_DEPTH) : {2'b0, cfg.entries_in_use};
  assign idx_ext  = {3'b0, item_r.entry_index};
  assign pend_ext = {3'b0, pend_r};

  // saturating elapsed counters
  assign run_inc = (run_r != 16'hFFFF) ? run_r + 16'd1 : run_r;
  assign cyc_inc = (cyc_r != 12'hFFF) ? cyc_r + 12'd1 : cyc_r;

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    run_nxt     = run_r;
    cyc_nxt     = cyc_r;
    step_nxt    = step_r;
    buzz_nxt    = buzz_r;
    cnt_nxt     = cnt_r;
    rd_pend_nxt = rd_pend_r;
    rd_idx_nxt  = rd_idx_r;
    ps          = step_r;
    cc          = cyc_inc;
    bz          = buzz_r;

    tbl_req.rd_en   = 1'b0;
    tbl_req.wr_en   = 1'b0;
    tbl_req.wr_data = '{on: item_r.entry_on, days: item_r.entry_days,
                        minute: item_r.entry_minute, hour: item_r.entry_hour};
    rd_addr = cnt_r[AW-1:0];
    wr_addr = idx_ext[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_nxt  = item;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_HOLD;
        unique case (item_r.op)
          OP_TICK: begin
            if (phase_r == PH_FIND) begin
              cnt_nxt     = '0;
              rd_pend_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end else if (phase_r == PH_WAIT) begin
              if (pend_ext < 7'(TABLE_DEPTH)) begin
                tbl_req.rd_en = 1'b1;
                rd_addr       = pend_ext[AW-1:0];
                state_nxt     = S_WCHK;
              end else begin
                phase_nxt = PH_FIND;
              end
            end else if (phase_r == PH_RUN) begin
              run_nxt = run_inc;
              cyc_nxt = cyc_inc;
              if (run_inc >= cfg.run_ms) begin
                phase_nxt = PH_FIND;
                buzz_nxt  = 1'b0;
              end else begin
                // short steps: on, off, on
                if (ps != 2'd3) begin
                  bz = ~ps[0];
                  if (cc >= cfg.short_ms) begin
                    ps = ps + 2'd1;
                    cc = '0;
                  end
                end
                // long silent pause
                if (ps == 2'd3) begin
                  bz = 1'b0;
                  if (cc >= cfg.long_ms) begin
                    ps = 2'd0;
                    cc = '0;
                  end
                end
                step_nxt = ps;
                cyc_nxt  = cc;
                buzz_nxt = bz;
              end
            end
          end
          OP_STOP: begin
            if (phase_r == PH_RUN) begin
              phase_nxt = PH_FIND;
              buzz_nxt  = 1'b0;
            end
          end
          OP_RECHECK: begin
            if (phase_r == PH_WAIT) begin
              phase_nxt = PH_FIND;
            end
          end
          OP_WRITE: begin
            if (idx_ext < 7'(TABLE_DEPTH)) begin
              tbl_req.wr_en = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // one read issued per cycle, the previous read checked alongside
        if (hit) begin
          pend_nxt    = rd_idx_r[3:0];
          phase_nxt   = PH_WAIT;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_HOLD;
        end else if (cnt_r < scan_n) begin
          tbl_req.rd_en = 1'b1;
          cnt_nxt       = cnt_r + 7'd1;
          rd_pend_nxt   = 1'b1;
          rd_idx_nxt    = cnt_r;
        end else if (!rd_pend_r) begin
          state_nxt = S_HOLD;
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end
      S_WCHK: begin
        state_nxt = S_HOLD;
        if (!rd_entry.on) begin
          phase_nxt = PH_FIND;
        end else if (now_mod == ent_mod) begin
          phase_nxt = PH_RUN;
          run_nxt   = '0;
          cyc_nxt   = '0;
          step_nxt  = '0;
        end
      end
      S_HOLD: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_FIND;
      pend_r    <= '0;
      run_r     <= '0;
      cyc_r     <= '0;
      step_r    <= '0;
      buzz_r    <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      pend_r    <= pend_nxt;
      run_r     <= run_nxt;
      cyc_r     <= cyc_nxt;
      step_r    <= step_nxt;
      buzz_r    <= buzz_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    cnt_r    <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_HOLD);
  assign res.buzzer_on     = buzz_r;
  assign res.phase         = phase_r;
  assign res.pending_index = pend_r;
  assign res.alarm_active  = (phase_r == PH_RUN);

  // buzzer only sounds while an alarm runs
  assert property (@(posedge clk) disable iff (!rst_n) buzz_r |-> (phase_r == PH_RUN))
    else $error("buzzer on outside running phase");

  // items are only taken between results
  assert property (@(posedge clk) disable iff (!rst_n) in_accept && !idle |=> state_r != S_EXEC)
    else $error("item taken while busy");

  // a waiting check always follows a table read
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_WCHK) |-> $past(tbl_req.rd_en))
    else $error("wait check without table read");

  // a held result stays until the output stage takes it
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_HOLD) && !res_ready |=> (state_r == S_HOLD) && $stable(res))
    else $error("result dropped before transfer");

endmodule

`default_nettype wire

// File: src/weekday_alarm_buzzer_sequencer_top.sv
// weekday alarm buzzer sequencer
// input stream (in_*): one transfer per item; tuser holds the operation (tick, stop,
// recheck, write entry), tdata the current time and the entry to write
// result stream (out_*): exactly one result transfer per input item, in order
// configuration (cfg_*): write-only registers, always ready; they must be written
// only while idle, which the block does not enforce; an item is processed alone,
// and the next item is taken once the previous result has left for the output
// register: stop, recheck, write and running ticks pass through execute and hold,
// a tick while waiting adds one table read and check, and a tick in the finding
// phase scans entries through the single table read port, one entry read per cycle
// reset: phase finding, counters and buzzer cleared, configuration at defaults,
// all table entries read as disabled (per-entry valid bits, no clearing pass)
// stall: results wait in an output register; one further item is taken and
// processed, then the block holds until the waiting result is transferred
`default_nettype none

module weekday_alarm_buzzer_sequencer_top import wabs_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // now_hour, now_minute, now_weekday, entry_index, entry_hour, entry_minute,
  // entry_days, entry_on, zero pad
  input  wire logic [39:0] in_tdata,
  // operation
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // buzzer_on, phase, pending_index, alarm_active
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t     cfg_r;
  item_t    item;
  res_t     res;
  logic     ctrl_idle;
  logic     res_valid;
  logic     res_ready;
  logic     in_xfer;
  tbl_req_t tbl_req;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  alarm_t   rd_entry;
  logic     out_valid_r;
  logic [7:0] out_data_r;

  // configuration registers, no back-pressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entries_in_use <= ENTRIES_RST;
      cfg_r.run_ms         <= RUN_MS_RST;
      cfg_r.short_ms       <= SHORT_MS_RST;
      cfg_r.long_ms        <= LONG_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENTRIES: cfg_r.entries_in_use <= cfg_data[4:0];
        CFG_RUN:     cfg_r.run_ms         <= cfg_data;
        CFG_SHORT:   cfg_r.short_ms       <= cfg_data[11:0];
        CFG_LONG:    cfg_r.long_ms        <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // unpack the input transfer
  assign item.op           = in_tuser;
  assign item.now_hour     = in_tdata[4:0];
  assign item.now_minute   = in_tdata[10:5];
  assign item.now_weekday  = in_tdata[13:11];
  assign item.entry_index  = in_tdata[17:14];
  assign item.entry_hour   = in_tdata[22:18];
  assign item.entry_minute = in_tdata[28:23];
  assign item.entry_days   = in_tdata[35:29];
  assign item.entry_on     = in_tdata[36];

  assign in_tready = ctrl_idle;
  assign in_xfer   = in_tvalid && in_tready;

  wabs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_xfer),
    .item      (item),
    .cfg       (cfg_r),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .tbl_req   (tbl_req),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .rd_entry  (rd_entry)
  );

  wabs_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .tbl_req  (tbl_req),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .rd_entry (rd_entry)
  );

  // output register: free when empty or being transferred this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {res.alarm_active, res.pending_index, res.phase, res.buzzer_on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wabs_pkg::*;

  localparam int DEPTH         = 16;
  localparam int N_DIR         = 25;
  localparam int PRE_CFG_ROWS  = 5;      // rows run with the reset configuration
  localparam int N_PHASES      = 10;
  localparam int PHASE_ITEMS   = 135;    // counted items per random phase
  localparam int SETTLE_CYCLES = 32;     // longer than the longest scan
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int LIMIT         = 1000000;

  localparam res_t IDLE_STATUS = '{buzzer_on: 1'b0, phase: PH_FIND,
                                   pending_index: 4'd0, alarm_active: 1'b0};

  // one row of the directed table
  typedef struct packed {
    item_t it;
    logic  typed;    // use want below instead of the predictor output
    res_t  want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // items waiting to be sent, and the status expected back for each
  item_t cmd_q[$];
  res_t  status_q[$];

  int    err_count = 0;
  int    cycles = 0;
  bit    no_idle = 1'b0;     // phase-wide stretch without idling
  bit    hold_req = 1'b0;    // asks the receiver for one long hold-off

  // predictor copy of the configuration
  logic [4:0]  scan_cnt;
  logic [15:0] run_len;
  logic [11:0] short_len;
  logic [11:0] long_len;

  // predictor copy of the sequencer state
  logic [1:0]  ph;
  logic [3:0]  pend;
  alarm_t      alarm_tbl [DEPTH];
  logic [15:0] run_cnt;
  logic [11:0] step_cnt;
  logic [1:0]  pat_step;
  logic        buzz;

  weekday_alarm_buzzer_sequencer_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reset held at the start, then released once
  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // minute of the day, kept to 11 bits, no wrap of hour or minute
  function automatic logic [10:0] day_minute(logic [4:0] h, logic [5:0] m);
    return 11'(h) * 11'd60 + 11'(m);
  endfunction

  // advance the predictor by one item and return the status it reports
  function automatic res_t predict_status(item_t it);
    res_t        st;
    logic [10:0] now;
    logic [7:0]  day_bit;
    int          n;
    bit          found;
    now = day_minute(it.now_hour, it.now_minute);
    day_bit = (it.now_weekday != 3'd0) ? (8'd1 << (it.now_weekday - 3'd1)) : 8'd0;
    case (it.op)
      OP_TICK: begin
        if (ph == PH_FIND) begin
          // first enabled alarm later today within the scanned entries
          n = (scan_cnt > DEPTH) ? DEPTH : int'(scan_cnt);
          found = 1'b0;
          for (int i = 0; i < DEPTH; i++) begin
            if (!found && i < n && alarm_tbl[i].on &&
                now < day_minute(alarm_tbl[i].hour, alarm_tbl[i].minute) &&
                (day_bit[6:0] & alarm_tbl[i].days) != 7'd0) begin
              pend = 4'(i);
              ph = PH_WAIT;
              found = 1'b1;
            end
          end
        end else if (ph == PH_WAIT) begin
          if (!alarm_tbl[pend].on) begin
            ph = PH_FIND;
          end else if (now == day_minute(alarm_tbl[pend].hour, alarm_tbl[pend].minute)) begin
            ph = PH_RUN;
            run_cnt = '0;
            step_cnt = '0;
            pat_step = '0;
          end
        end else if (ph == PH_RUN) begin
          if (run_cnt != 16'hFFFF) run_cnt++;
          if (step_cnt != 12'hFFF) step_cnt++;
          if (run_cnt >= run_len) begin
            ph = PH_FIND;
            buzz = 1'b0;
          end else begin
            // on, off, on for short_len each, then silent for long_len
            if (pat_step <= 2'd2) begin
              buzz = ~pat_step[0];
              if (step_cnt >= short_len) begin
                pat_step++;
                step_cnt = '0;
              end
            end
            if (pat_step == 2'd3) begin
              buzz = 1'b0;
              if (step_cnt >= long_len) begin
                pat_step = '0;
                step_cnt = '0;
              end
            end
          end
        end
      end
      OP_STOP: begin
        if (ph == PH_RUN) begin
          ph = PH_FIND;
          buzz = 1'b0;
        end
      end
      OP_RECHECK: begin
        if (ph == PH_WAIT) ph = PH_FIND;
      end
      default: begin
        alarm_tbl[it.entry_index].hour   = it.entry_hour;
        alarm_tbl[it.entry_index].minute = it.entry_minute;
        alarm_tbl[it.entry_index].days   = it.entry_days;
        alarm_tbl[it.entry_index].on     = it.entry_on;
      end
    endcase
    st.buzzer_on     = buzz;
    st.phase         = ph;
    st.pending_index = pend;
    st.alarm_active  = (ph == PH_RUN);
    return st;
  endfunction

  function automatic item_t mk_item(logic [1:0] op, logic [4:0] nh, logic [5:0] nm,
                                    logic [2:0] nw, logic [3:0] ei, logic [4:0] eh,
                                    logic [5:0] em, logic [6:0] ed, logic eo);
    item_t it;
    it.op = op;
    it.now_hour = nh;
    it.now_minute = nm;
    it.now_weekday = nw;
    it.entry_index = ei;
    it.entry_hour = eh;
    it.entry_minute = em;
    it.entry_days = ed;
    it.entry_on = eo;
    return it;
  endfunction

  // every field at full width, unused ones included
  function automatic item_t rand_fields();
    return mk_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                   6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                   6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)));
  endfunction

  // write of a plausible alarm, now and then a raw one
  function automatic item_t rand_entry_write();
    item_t it;
    it = rand_fields();
    it.op = OP_WRITE;
    if ($urandom_range(0, 9) != 0) begin
      it.entry_hour   = 5'($urandom_range(0, 23));
      it.entry_minute = 6'($urandom_range(0, 59));
      if (it.entry_days == 7'd0 || $urandom_range(0, 4) == 0)
        it.entry_days = 7'($urandom_range(1, 127));
      it.entry_on = ($urandom_range(0, 6) != 0);
    end
    return it;
  endfunction

  task automatic queue_item(input item_t it, input logic typed, input res_t want);
    res_t st;
    st = predict_status(it);
    status_q.push_back(typed ? want : st);
    cmd_q.push_back(it);
  endtask

  // random traffic steered by the predicted phase, so that alarms get found,
  // matched and run through their pattern, with noise on top
  task automatic queue_random(input int want_items);
    int          done_items;
    int          r;
    int          k;
    int          lim;
    int          t;
    int          d;
    item_t       it;
    logic [10:0] am;
    done_items = 0;
    repeat ($urandom_range(4, 8)) begin
      queue_item(rand_entry_write(), 1'b0, IDLE_STATUS);
      done_items++;
    end
    while (done_items < want_items) begin
      it = rand_fields();
      r = $urandom_range(0, 99);
      case (ph)
        PH_FIND: begin
          if (r < 65) begin
            // tick a few minutes ahead of some alarm on one of its days
            it.op = OP_TICK;
            lim = (scan_cnt == 5'd0 || scan_cnt > DEPTH) ? DEPTH : int'(scan_cnt);
            k = $urandom_range(0, lim - 1);
            am = day_minute(alarm_tbl[k].hour, alarm_tbl[k].minute);
            if (alarm_tbl[k].on && alarm_tbl[k].days != 7'd0 &&
                alarm_tbl[k].hour <= 5'd23 && am != 11'd0) begin
              t = int'(am) - $urandom_range(1, 4);
              if (t < 0) t = 0;
              it.now_hour = 5'(t / 60);
              it.now_minute = 6'(t % 60);
              do d = $urandom_range(0, 6); while (!alarm_tbl[k].days[d]);
              it.now_weekday = 3'(d + 1);
            end else begin
              it.now_hour = 5'($urandom_range(0, 23));
              it.now_minute = 6'($urandom_range(0, 59));
              it.now_weekday = 3'($urandom_range(1, 7));
            end
          end else if (r < 80) begin
            it = rand_entry_write();
          end else if (r < 90) begin
            it.op = (r < 85) ? OP_STOP : OP_RECHECK;
          end else begin
            it.op = OP_TICK;
          end
        end
        PH_WAIT: begin
          if (r < 45) begin
            // the pending alarm's own minute starts it
            it.op = OP_TICK;
            it.now_hour = alarm_tbl[pend].hour;
            it.now_minute = alarm_tbl[pend].minute;
          end else if (r < 65) begin
            it.op = OP_TICK;
            it.now_hour = 5'($urandom_range(0, 23));
            it.now_minute = 6'($urandom_range(0, 59));
          end else if (r < 75) begin
            it.op = OP_RECHECK;
          end else if (r < 85) begin
            it = rand_entry_write();
            if (r < 80) begin
              // disable the alarm being waited on
              it.entry_index = pend;
              it.entry_on = 1'b0;
            end
          end else if (r < 92) begin
            it.op = OP_STOP;
          end else begin
            it.op = OP_TICK;
          end
        end
        default: begin
          if (r < 85) it.op = OP_TICK;
          else if (r < 91) it.op = OP_STOP;
          else if (r < 95) it.op = OP_RECHECK;
          else it = rand_entry_write();
        end
      endcase
      done_items++;
      queue_item(it, 1'b0, IDLE_STATUS);
    end
  endtask

  // one register transfer; caller stands at a rising edge
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENTRIES: scan_cnt = val[4:0];
      CFG_RUN:     run_len = val;
      CFG_SHORT:   short_len = val[11:0];
      default:     long_len = val[11:0];
    endcase
  endtask

  task automatic apply_cfg(input int e, input int rl, input int sl, input int ll);
    write_reg(CFG_ENTRIES, 16'(e));
    write_reg(CFG_RUN, 16'(rl));
    write_reg(CFG_SHORT, 16'(sl));
    write_reg(CFG_LONG, 16'(ll));
    cfg_valid <= 1'b0;
  endtask

  // every sent item answered, then let the block settle
  task automatic wait_idle();
    while (cmd_q.size() != 0 || status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // sender: one transfer per accepted item, valid held until ready
  initial begin
    int gap_left;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_TICK;
    gap_left  = 0;
    forever begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        cmd_q.delete(0);
        gap_left = pick_gap();
      end
      if (!in_tvalid || in_tready) begin
        if (!rst_n || gap_left > 0 || cmd_q.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= {3'b000, cmd_q[0].entry_on, cmd_q[0].entry_days,
                        cmd_q[0].entry_minute, cmd_q[0].entry_hour, cmd_q[0].entry_index,
                        cmd_q[0].now_weekday, cmd_q[0].now_minute, cmd_q[0].now_hour};
          in_tuser  <= cmd_q[0].op;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest expected status
  initial begin
    int   stall_left;
    res_t got;
    res_t want;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.buzzer_on     = out_tdata[0];
        got.phase         = out_tdata[2:1];
        got.pending_index = out_tdata[6:3];
        got.alarm_active  = out_tdata[7];
        if (status_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, out_tdata);
          err_count++;
        end else begin
          want = status_q.pop_front();
          cmp_field("buzzer_on", want.buzzer_on, got.buzzer_on);
          cmp_field("phase", want.phase, got.phase);
          cmp_field("pending_index", want.pending_index, got.pending_index);
          cmp_field("alarm_active", want.alarm_active, got.alarm_active);
        end
        stall_left = pick_gap();
      end
      // long hold-off so the block fills up and stalls its input
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // cycle limit
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // main sequence: directed table, then random phases under varied settings
  initial begin
    dir_row_t rows [N_DIR];
    int       e;
    int       rl;
    int       sl;
    int       ll;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENTRIES;
    cfg_data  = '0;

    // predictor after reset
    scan_cnt  = ENTRIES_RST;
    run_len   = RUN_MS_RST;
    short_len = SHORT_MS_RST;
    long_len  = LONG_MS_RST;
    ph        = PH_FIND;
    pend      = '0;
    run_cnt   = '0;
    step_cnt  = '0;
    pat_step  = '0;
    buzz      = 1'b0;
    for (int i = 0; i < DEPTH; i++) alarm_tbl[i] = '0;

    // with zero entries scanned nothing can be found
    rows[0]  = '{mk_item(OP_TICK,     0,  0, 1,  0,  0,  0, 7'h00, 0), 1'b1, IDLE_STATUS};
    rows[1]  = '{mk_item(OP_WRITE,    0,  0, 0,  0,  0,  2, 7'h01, 1), 1'b1, IDLE_STATUS};
    rows[2]  = '{mk_item(OP_WRITE,    0,  0, 0, 15, 23, 59, 7'h7F, 1), 1'b1, IDLE_STATUS};
    rows[3]  = '{mk_item(OP_WRITE,    0,  0, 0,  1, 31, 63, 7'h7F, 0), 1'b1, IDLE_STATUS};
    rows[4]  = '{mk_item(OP_TICK,    23, 59, 7,  0,  0,  0, 7'h00, 0), 1'b1, IDLE_STATUS};
    // weekday zero matches no alarm
    rows[5]  = '{mk_item(OP_TICK,     0,  0, 0,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[6]  = '{mk_item(OP_TICK,     0,  0, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[7]  = '{mk_item(OP_RECHECK,  0,  0, 0,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[8]  = '{mk_item(OP_TICK,     0,  0, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[9]  = '{mk_item(OP_TICK,     0,  1, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    // minute match starts the alarm, buzzer still off
    rows[10] = '{mk_item(OP_TICK,     0,  2, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[11] = '{mk_item(OP_TICK,     5,  5, 5,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[12] = '{mk_item(OP_TICK,     0,  0, 0,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    // recheck is ignored while running
    rows[13] = '{mk_item(OP_RECHECK,  0,  0, 0,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[14] = '{mk_item(OP_TICK,    31, 63, 7,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[15] = '{mk_item(OP_WRITE,    0,  0, 0,  2, 12, 30, 7'h55, 1), 1'b0, IDLE_STATUS};
    rows[16] = '{mk_item(OP_TICK,     0,  0, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    // stop silences and returns to finding, then does nothing outside running
    rows[17] = '{mk_item(OP_STOP,     0,  0, 0,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[18] = '{mk_item(OP_STOP,     0,  0, 0,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[19] = '{mk_item(OP_TICK,     0,  0, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    // disabling the pending alarm drops back to finding
    rows[20] = '{mk_item(OP_WRITE,    0,  0, 0,  0,  0,  2, 7'h01, 0), 1'b0, IDLE_STATUS};
    rows[21] = '{mk_item(OP_TICK,     0,  1, 1,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[22] = '{mk_item(OP_TICK,    23, 58, 7,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    // hour and minute beyond range do not wrap
    rows[23] = '{mk_item(OP_TICK,    31, 63, 7,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};
    rows[24] = '{mk_item(OP_TICK,    23, 59, 3,  0,  0,  0, 7'h00, 0), 1'b0, IDLE_STATUS};

    do @(posedge clk); while (!rst_n);

    for (int i = 0; i < PRE_CFG_ROWS; i++) queue_item(rows[i].it, rows[i].typed, rows[i].want);
    wait_idle();
    apply_cfg(16, 10, 1, 2);
    for (int i = PRE_CFG_ROWS; i < N_DIR; i++)
      queue_item(rows[i].it, rows[i].typed, rows[i].want);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin e = 16; rl = 65535; sl = 4095; ll = 4095; end
        1: begin e = 31; rl = 0; sl = 0; ll = 0; end
        2: begin e = 1; rl = 1; sl = 1; ll = 1; end
        3: begin e = 0; rl = RUN_MS_RST; sl = SHORT_MS_RST; ll = LONG_MS_RST; end
        default: begin
          e  = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
          rl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(4, 90);
          sl = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
          ll = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        end
      endcase
      apply_cfg(e, rl, sl, ll);
      no_idle = (p >= 4 && $urandom_range(0, 3) == 0);
      queue_random(PHASE_ITEMS);
      if (p == 2) hold_req = 1'b1;
      wait_idle();
    end

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
